### src/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

    // Field widths of the stream items.
    localparam int IN_W      = 18;
    localparam int HEAD_W    = 16;
    localparam int CNT_OUT_W = 4;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam int WINDOW_DEFAULT = 8;

    // Angle register for range reduction: holds -131072 to 131071.
    localparam int ANG_W = 19;

    // CORDIC angles are centidegrees times 256.
    localparam int ZW           = 25;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int Q15_W        = 16;

    localparam int CORDIC_X0 = 5093961;

    localparam logic signed [ANG_W-1:0] FULL_TURN    = 36000;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 9000;
    localparam logic signed [ZW-1:0]    Z_FULL_TURN  = 36000;
    localparam logic signed [ZW-1:0]    Z_HALF_TURN  = 4608000;
    localparam logic signed [ZW-1:0]    Z_ROUND      = 128;

    // atan(2^-i) in centidegrees times 256, rounded to nearest.
    localparam logic signed [ZW-1:0] ATAN_Q8 [CORDIC_STEPS] = '{
        25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
        25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
        25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
        25'sd358,     25'sd179,    25'sd90,     25'sd45
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_QUAD,
        ST_ROT,
        ST_SINCOS,
        ST_UPDATE,
        ST_VEC_INIT,
        ST_VEC,
        ST_FINISH
    } t_chs_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              reduce;
        logic              quad;
        logic              rot_init;
        logic              step_en;
        logic              rot_mode;
        logic [STEP_W-1:0] step;
        logic              sincos;
        logic              update;
        logic              vec_init;
        logic              finish;
    } t_chs_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;
        logic rem_small;
        logic out_free;
    } t_chs_stat;

endpackage

`default_nettype wire

### src/circular_heading_smoother_top.sv
// Circular moving average of heading samples.
//
// Input channel (s_*): one heading per item in centidegrees, tdata[17:0],
// signed. Output channel (m_*): one result per input item, tdata[15:0] the
// smoothed heading 0..35999 and tdata[19:16] the number of samples held.
//
// An item is taken only while the block is idle. It first passes a range
// reduction and a quadrant split, then the CORDIC rotation, rounding to
// sine and cosine, the window update, the vectoring set-up and the CORDIC
// vectoring. The result is then loaded into the output register, and the
// next item can be accepted in the cycle after the load. The block takes no
// new item before the last one is through, since one CORDIC iteration is
// shared by rotation and vectoring.
//
// Reset (synchronous, active low) empties the window and drops any pending
// result. A stalled receiver holds the result in the output register while
// the next item is already processed; that item waits in its last step until
// the register is taken.
`timescale 1ns / 1ps
`default_nettype none

module circular_heading_smoother_top #(
    parameter int WINDOW = chs_pkg::WINDOW_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [17:0] heading_in
    input  wire logic [chs_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [15:0] heading_out, [19:16] samples_held
    output logic [chs_pkg::M_TDATA_W-1:0]      o_m_tdata
);

    chs_pkg::t_chs_cmd  cmd;
    chs_pkg::t_chs_stat stat;
    logic [chs_pkg::HEAD_W-1:0]    heading_out;
    logic [chs_pkg::CNT_OUT_W-1:0] samples_held;

    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    chs_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_heading_in   (i_s_tdata[chs_pkg::IN_W-1:0]),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_heading_out  (heading_out),
        .o_samples_held (samples_held)
    );

    assign o_m_tdata = {
        (chs_pkg::M_TDATA_W - chs_pkg::HEAD_W - chs_pkg::CNT_OUT_W)'(0),
        samples_held,
        heading_out
    };

endmodule

`default_nettype wire

### src/chs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module chs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire chs_pkg::t_chs_stat i_stat,
    output chs_pkg::t_chs_cmd       o_cmd
);

    chs_pkg::t_chs_state r_state;
    chs_pkg::t_chs_state n_state;
    logic [chs_pkg::STEP_W-1:0] r_step;
    logic [chs_pkg::STEP_W-1:0] n_step;
    logic step_last;

    assign step_last = (r_step == chs_pkg::STEP_W'(chs_pkg::CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chs_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chs_pkg::ST_IDLE:     if (i_s_tvalid) n_state = chs_pkg::ST_REDUCE;
            chs_pkg::ST_REDUCE:   if (i_stat.in_range) n_state = chs_pkg::ST_QUAD;
            chs_pkg::ST_QUAD:     if (i_stat.rem_small) n_state = chs_pkg::ST_ROT;
            chs_pkg::ST_ROT:      if (step_last) n_state = chs_pkg::ST_SINCOS;
            chs_pkg::ST_SINCOS:   n_state = chs_pkg::ST_UPDATE;
            chs_pkg::ST_UPDATE:   n_state = chs_pkg::ST_VEC_INIT;
            chs_pkg::ST_VEC_INIT: n_state = chs_pkg::ST_VEC;
            chs_pkg::ST_VEC:      if (step_last) n_state = chs_pkg::ST_FINISH;
            chs_pkg::ST_FINISH:   if (i_stat.out_free) n_state = chs_pkg::ST_IDLE;
            default:              n_state = chs_pkg::ST_IDLE;
        endcase
    end

    // Outputs and step counter.
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        n_step     = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            chs_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            chs_pkg::ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
            end
            chs_pkg::ST_QUAD: begin
                o_cmd.quad     = !i_stat.rem_small;
                o_cmd.rot_init = i_stat.rem_small;
            end
            chs_pkg::ST_ROT: begin
                o_cmd.step_en  = 1'b1;
                o_cmd.rot_mode = 1'b1;
                n_step         = r_step + 1'b1;
            end
            chs_pkg::ST_SINCOS: begin
                o_cmd.sincos = 1'b1;
            end
            chs_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            chs_pkg::ST_VEC_INIT: begin
                o_cmd.vec_init = 1'b1;
            end
            chs_pkg::ST_VEC: begin
                o_cmd.step_en = 1'b1;
                n_step        = r_step + 1'b1;
            end
            chs_pkg::ST_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The step counter runs only inside the two CORDIC loops.
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> (r_state == chs_pkg::ST_ROT || r_state == chs_pkg::ST_VEC))
        else $error("step counter active outside CORDIC loop");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chs_pkg::ST_IDLE && i_s_tvalid) |=> (r_state == chs_pkg::ST_REDUCE))
        else $error("accepted item did not start reduction");

    a_rot_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chs_pkg::ST_ROT && step_last) |=> (r_state == chs_pkg::ST_SINCOS))
        else $error("rotation loop did not end after its last step");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chs_pkg::ST_FINISH && !i_stat.out_free) |=>
        (r_state == chs_pkg::ST_FINISH))
        else $error("left finish while the output register was occupied");

endmodule

`default_nettype wire

### src/chs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module chs_datapath #(
    parameter int WINDOW = chs_pkg::WINDOW_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire chs_pkg::t_chs_cmd               i_cmd,
    output chs_pkg::t_chs_stat                   o_stat,
    input  wire logic [chs_pkg::IN_W-1:0]        i_heading_in,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [chs_pkg::HEAD_W-1:0]           o_heading_out,
    output logic [chs_pkg::CNT_OUT_W-1:0]        o_samples_held
);

    localparam int TOTAL_W = 17 + $clog2(WINDOW);
    localparam int CW      = TOTAL_W + 10;
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int ZW      = chs_pkg::ZW;

    localparam logic signed [CW-1:0] C_ROUND = 128;
    localparam logic signed [CW-1:0] Q_MAX   = 32767;
    localparam logic signed [CW-1:0] Q_MIN   = -32767;

    function automatic logic signed [chs_pkg::Q15_W-1:0] to_q15(
        input logic signed [CW-1:0] v
    );
        logic signed [CW-1:0] r;
        r = (v + C_ROUND) >>> 8;
        if (r > Q_MAX) begin
            r = Q_MAX;
        end else if (r < Q_MIN) begin
            r = Q_MIN;
        end
        return r[chs_pkg::Q15_W-1:0];
    endfunction

    logic signed [chs_pkg::ANG_W-1:0] r_ang;
    logic [1:0]                       r_quad;
    logic signed [CW-1:0]             r_x;
    logic signed [CW-1:0]             r_y;
    logic signed [ZW-1:0]             r_z;
    logic signed [chs_pkg::Q15_W-1:0] r_sin;
    logic signed [chs_pkg::Q15_W-1:0] r_cos;
    logic signed [chs_pkg::Q15_W-1:0] r_old_sin;
    logic signed [chs_pkg::Q15_W-1:0] r_old_cos;
    logic signed [chs_pkg::Q15_W-1:0] r_sin_ring [WINDOW];
    logic signed [chs_pkg::Q15_W-1:0] r_cos_ring [WINDOW];
    logic [SLOT_W-1:0]                r_slot;
    logic [FILL_W-1:0]                r_fill;
    logic signed [TOTAL_W-1:0]        r_sin_total;
    logic signed [TOTAL_W-1:0]        r_cos_total;
    logic                             r_out_valid;
    logic [chs_pkg::HEAD_W-1:0]       r_heading;
    logic [chs_pkg::CNT_OUT_W-1:0]    r_count;

    // CORDIC step, shared by rotation (sine/cosine) and vectoring (atan2).
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] t_step;
    logic                 turn_pos;
    assign dx       = r_y >>> i_cmd.step;
    assign dy       = r_x >>> i_cmd.step;
    assign t_step   = chs_pkg::ATAN_Q8[i_cmd.step];
    assign turn_pos = i_cmd.rot_mode ? !r_z[ZW-1] : r_y[CW-1];

    // Q1.15 results of the rotation and quadrant mapping.
    logic signed [chs_pkg::Q15_W-1:0] s_q;
    logic signed [chs_pkg::Q15_W-1:0] c_q;
    logic signed [chs_pkg::Q15_W-1:0] n_sin;
    logic signed [chs_pkg::Q15_W-1:0] n_cos;
    assign s_q = to_q15(r_y);
    assign c_q = to_q15(r_x);

    always_comb begin
        case (r_quad)
            2'd0: begin
                n_sin = s_q;
                n_cos = c_q;
            end
            2'd1: begin
                n_sin = c_q;
                n_cos = -s_q;
            end
            2'd2: begin
                n_sin = -s_q;
                n_cos = -c_q;
            end
            default: begin
                n_sin = -c_q;
                n_cos = s_q;
            end
        endcase
    end

    // Window bookkeeping. The outgoing entry is read in the cycle before the update.
    logic                      full;
    logic signed [TOTAL_W-1:0] old_sin;
    logic signed [TOTAL_W-1:0] old_cos;
    logic signed [TOTAL_W-1:0] n_sin_total;
    logic signed [TOTAL_W-1:0] n_cos_total;
    assign full    = (r_fill == FILL_W'(WINDOW));
    assign old_sin = full ? TOTAL_W'(r_old_sin) : '0;
    assign old_cos = full ? TOTAL_W'(r_old_cos) : '0;
    assign n_sin_total = r_sin_total - old_sin + TOTAL_W'(r_sin);
    assign n_cos_total = r_cos_total - old_cos + TOTAL_W'(r_cos);

    // Vectoring start values and final rounding.
    logic signed [CW-1:0] sin_ext;
    logic signed [CW-1:0] cos_ext;
    logic                 sums_zero;
    logic signed [ZW-1:0] h_raw;
    logic signed [ZW-1:0] h_wrap;
    assign sin_ext   = CW'(r_sin_total);
    assign cos_ext   = CW'(r_cos_total);
    assign sums_zero = (r_sin_total == '0) && (r_cos_total == '0);
    assign h_raw     = (r_z + chs_pkg::Z_ROUND) >>> 8;

    always_comb begin
        if (h_raw < 0) begin
            h_wrap = h_raw + chs_pkg::Z_FULL_TURN;
        end else if (h_raw >= chs_pkg::Z_FULL_TURN) begin
            h_wrap = h_raw - chs_pkg::Z_FULL_TURN;
        end else begin
            h_wrap = h_raw;
        end
    end

    assign o_stat.in_range  = !r_ang[chs_pkg::ANG_W-1] && (r_ang < chs_pkg::FULL_TURN);
    assign o_stat.rem_small = (r_ang < chs_pkg::QUARTER_TURN);
    assign o_stat.out_free  = !r_out_valid || i_ready;

    // Angle reduction, CORDIC, sine/cosine, window ring and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ang  <= chs_pkg::ANG_W'($signed(i_heading_in));
            r_quad <= '0;
        end else if (i_cmd.reduce) begin
            if (r_ang[chs_pkg::ANG_W-1]) begin
                r_ang <= r_ang + chs_pkg::FULL_TURN;
            end else if (r_ang >= chs_pkg::FULL_TURN) begin
                r_ang <= r_ang - chs_pkg::FULL_TURN;
            end
        end else if (i_cmd.quad) begin
            r_ang  <= r_ang - chs_pkg::QUARTER_TURN;
            r_quad <= r_quad + 2'd1;
        end

        if (i_cmd.rot_init) begin
            r_x <= CW'(chs_pkg::CORDIC_X0);
            r_y <= '0;
            r_z <= ZW'(r_ang) <<< 8;
        end else if (i_cmd.vec_init) begin
            if (cos_ext < 0) begin
                r_x <= (-cos_ext) <<< 8;
                r_y <= (-sin_ext) <<< 8;
                r_z <= chs_pkg::Z_HALF_TURN;
            end else begin
                r_x <= cos_ext <<< 8;
                r_y <= sin_ext <<< 8;
                r_z <= '0;
            end
        end else if (i_cmd.step_en) begin
            if (turn_pos) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - t_step;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + t_step;
            end
        end

        if (i_cmd.sincos) begin
            r_sin     <= n_sin;
            r_cos     <= n_cos;
            r_old_sin <= r_sin_ring[r_slot];
            r_old_cos <= r_cos_ring[r_slot];
        end

        if (i_cmd.update) begin
            r_sin_ring[r_slot] <= r_sin;
            r_cos_ring[r_slot] <= r_cos;
        end

        if (i_cmd.finish) begin
            r_heading <= sums_zero ? '0 : h_wrap[chs_pkg::HEAD_W-1:0];
            r_count   <= chs_pkg::CNT_OUT_W'(r_fill);
        end
    end

    // Window state and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_fill      <= '0;
            r_sin_total <= '0;
            r_cos_total <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_sin_total <= n_sin_total;
                r_cos_total <= n_cos_total;
                if (!full) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_slot == SLOT_W'(WINDOW - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_heading_out  = r_heading;
    assign o_samples_held = r_count;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fill count beyond window size");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_heading < chs_pkg::HEAD_W'(36000)))
        else $error("result heading out of range");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SMOOTH_WINDOW   = chs_pkg::WINDOW_DEFAULT;
    localparam int TURN_CD         = 36000;
    localparam int QUARTER_CD      = 9000;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int DIR_ROWS        = 23;

    typedef struct {
        logic [chs_pkg::HEAD_W-1:0]    heading;
        logic [chs_pkg::CNT_OUT_W-1:0] held;
    } t_smoothed;

    // One directed item. A nonzero held marks a row where the window cancels
    // out exactly: heading 0 with that many samples held.
    typedef struct packed {
        logic signed [chs_pkg::IN_W-1:0] sample;
        logic [chs_pkg::CNT_OUT_W-1:0]   held;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [chs_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [chs_pkg::M_TDATA_W-1:0] o_m_tdata;

    t_smoothed pending_smoothed[$];
    int        error_count = 0;
    bit        hold_off_req = 1'b0;
    bit        rx_eager = 1'b0;

    // Window state of the predictor.
    int sin_win [SMOOTH_WINDOW];
    int cos_win [SMOOTH_WINDOW];
    int win_slot = 0;
    int win_fill = 0;
    int sin_sum = 0;
    int cos_sum = 0;

    const longint atan_cd_q8 [chs_pkg::CORDIC_STEPS] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45
    };

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{18'sd0, 4'd0},
        '{18'sd18000, 4'd2},
        '{18'sd9000, 4'd0},
        '{18'sd27000, 4'd4},
        '{-18'sd36000, 4'd0},
        '{18'sd54000, 4'd6},
        '{-18'sd18000, 4'd0},
        '{18'sd36000, 4'd8},
        '{18'sd0, 4'd8},
        '{-18'sd131072, 4'd0},
        '{18'sd131071, 4'd0},
        '{18'sd35999, 4'd0},
        '{18'sd71999, 4'd0},
        '{-18'sd1, 4'd0},
        '{-18'sd35999, 4'd0},
        '{18'sd72000, 4'd0},
        '{-18'sd36001, 4'd0},
        '{18'sd4500, 4'd0},
        '{18'sd13500, 4'd0},
        '{18'sd22500, 4'd0},
        '{18'sd31500, 4'd0},
        '{18'sd8999, 4'd0},
        '{18'sd100, 4'd0}
    };

    circular_heading_smoother_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Bring a sample into 0..35999; values that one turn cannot fix take the
    // true residue.
    function automatic int reduce_heading(input int v);
        if (v < 0) begin
            v += TURN_CD;
        end else if (v >= TURN_CD) begin
            v -= TURN_CD;
        end
        if (v < 0 || v >= TURN_CD) begin
            v = v % TURN_CD;
            if (v < 0) begin
                v += TURN_CD;
            end
        end
        return v;
    endfunction

    function automatic int round_q15(input longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32767) begin
            r = -32767;
        end
        return int'(r);
    endfunction

    task automatic heading_sin_cos(input int angle, output int sn, output int cs);
        int     quad;
        int     s;
        int     c;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        quad = (angle / QUARTER_CD) & 3;
        x = chs_pkg::CORDIC_X0;
        y = 0;
        z = longint'(angle % QUARTER_CD) * 256;
        for (int i = 0; i < chs_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_cd_q8[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_cd_q8[i];
            end
        end
        s = round_q15(y);
        c = round_q15(x);
        case (quad)
            0: begin
                sn = s;
                cs = c;
            end
            1: begin
                sn = c;
                cs = -s;
            end
            2: begin
                sn = -s;
                cs = -c;
            end
            default: begin
                sn = -c;
                cs = s;
            end
        endcase
    endtask

    function automatic int heading_atan2(input longint y, input longint x);
        longint z;
        longint h;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd18000 * 256;
        end
        x *= 256;
        y *= 256;
        for (int i = 0; i < chs_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += atan_cd_q8[i];
            end else begin
                x -= dx;
                y += dy;
                z -= atan_cd_q8[i];
            end
        end
        h = (z + 128) >>> 8;
        if (h < 0) begin
            h += TURN_CD;
        end else if (h >= TURN_CD) begin
            h -= TURN_CD;
        end
        return int'(h);
    endfunction

    // Push one sample through the window and work out the smoothed heading.
    task automatic smooth_heading(input logic signed [chs_pkg::IN_W-1:0] sample,
                                  output t_smoothed res);
        int sn;
        int cs;
        heading_sin_cos(reduce_heading(int'(sample)), sn, cs);
        if (win_fill < SMOOTH_WINDOW) begin
            win_fill++;
        end else begin
            sin_sum -= sin_win[win_slot];
            cos_sum -= cos_win[win_slot];
        end
        sin_win[win_slot] = sn;
        cos_win[win_slot] = cs;
        sin_sum += sn;
        cos_sum += cs;
        win_slot = (win_slot + 1) % SMOOTH_WINDOW;
        res.heading = chs_pkg::HEAD_W'(heading_atan2(sin_sum, cos_sum));
        res.held = chs_pkg::CNT_OUT_W'(win_fill);
    endtask

    task automatic send_heading(input logic signed [chs_pkg::IN_W-1:0] sample,
                                input int gap,
                                input logic [chs_pkg::CNT_OUT_W-1:0] typed_held);
        t_smoothed want;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(chs_pkg::S_TDATA_W - chs_pkg::IN_W){1'b0}}, sample};
        @(posedge i_clk);
        while (!(i_s_tvalid && o_s_tready)) @(posedge i_clk);
        smooth_heading(sample, want);
        if (typed_held != 0) begin
            want.heading = '0;
            want.held = typed_held;
        end
        pending_smoothed.push_back(want);
    endtask

    task automatic wait_drained;
        while (pending_smoothed.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [chs_pkg::IN_W-1:0] pick_heading(input int base,
                                                                     input int spread);
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (spread >= 0) begin
            // Clustered around base, possibly a whole turn away, to exercise
            // averaging across the wrap.
            v = base + $urandom_range(0, 2 * spread) - spread;
            v += TURN_CD * ($urandom_range(0, 2) - 1);
        end else if (pick < 6) begin
            v = $urandom_range(0, 107999) - TURN_CD;
        end else if (pick < 8) begin
            v = $urandom_range(0, TURN_CD - 1);
        end else if (pick < 9) begin
            v = QUARTER_CD * $urandom_range(0, 7) + $urandom_range(0, 4) - 2;
        end else begin
            v = $urandom_range(0, 262143);
        end
        return chs_pkg::IN_W'(v);
    endfunction

    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else if (rx_eager) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
            end
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(o_m_tvalid && i_m_tready)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_smoothed want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_smoothed.size() == 0) begin
                report_mismatch($sformatf("unexpected item: heading %0d held %0d",
                                o_m_tdata[chs_pkg::HEAD_W-1:0],
                                o_m_tdata[chs_pkg::HEAD_W +: chs_pkg::CNT_OUT_W]));
            end else begin
                want = pending_smoothed.pop_front();
                if (o_m_tdata[chs_pkg::HEAD_W-1:0] !== want.heading) begin
                    report_mismatch($sformatf("heading_out %0d, expected %0d",
                                    o_m_tdata[chs_pkg::HEAD_W-1:0], want.heading));
                end
                if (o_m_tdata[chs_pkg::HEAD_W +: chs_pkg::CNT_OUT_W] !== want.held) begin
                    report_mismatch($sformatf("samples_held %0d, expected %0d",
                                    o_m_tdata[chs_pkg::HEAD_W +: chs_pkg::CNT_OUT_W],
                                    want.held));
                end
                if (o_m_tdata[chs_pkg::M_TDATA_W-1:chs_pkg::HEAD_W+chs_pkg::CNT_OUT_W]
                    !== '0) begin
                    report_mismatch($sformatf("tdata padding %0h is not zero",
                        o_m_tdata[chs_pkg::M_TDATA_W-1:chs_pkg::HEAD_W+chs_pkg::CNT_OUT_W]));
                end
            end
        end
    end

    initial begin : heading_source
        int sent;
        int burst;
        int burst_len;
        int base;
        int spread;
        bit eager;
        for (int i = 0; i < SMOOTH_WINDOW; i++) begin
            sin_win[i] = 0;
            cos_win[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_heading(dir_rows[i].sample, $urandom_range(0, 15), dir_rows[i].held);
        end
        i_s_tvalid <= 1'b0;
        wait_drained();

        sent = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS) begin
            if (burst % 25 == 24) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
            end
            burst_len = $urandom_range(1, 20);
            spread = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 3000);
            base = $urandom_range(0, TURN_CD - 1);
            eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            // Receiver holds off while items keep coming, so the block fills.
            if (burst == 5 || burst == 40) begin
                hold_off_req = 1'b1;
                eager = 1'b1;
                burst_len = 8;
            end
            for (int k = 0; k < burst_len; k++) begin
                send_heading(pick_heading(base, spread),
                             eager ? 0 : $urandom_range(0, 15), '0);
                sent++;
            end
            burst++;
        end
        i_s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
src/chs_pkg.sv
src/chs_ctrl.sv
src/chs_datapath.sv
src/circular_heading_smoother_top.sv
tb/tb_top.sv
